>>> rtl/core/rlt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlt_pkg: shared types and constants of the run-length table
// Field widths, request codes, result status codes, controller states and the
// command and status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package rlt_pkg;

    localparam int VAL_W = 32;   // width of a stored or returned value
    localparam int IDX_W = 22;   // width of a lookup position

    // request codes carried on req_type
    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic do_append;   // apply an append item this cycle
        logic do_lookup;   // open a lookup item this cycle
        logic do_walk;     // take one run of the walk this cycle
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic in_range;    // offered lookup position lies below the item count
        logic hit;         // the run read this cycle holds the position
    } dp_status_t;

endpackage

>>> rtl/core/rlt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlt_ram: generic single-write, single-read RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module rlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/rlt_fsm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlt_fsm: controller of the run-length table
// Accepts items while idle and sequences the run walk of a lookup.
// ----------------------------------------------------------------------------
module rlt_fsm
    import rlt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       req_type,
    input  dp_status_t stat,
    output logic       busy,
    output ctrl_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && (req_type == REQ_LOOKUP) && stat.in_range)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (stat.hit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        busy          = 1'b0;
        cmd.do_append = 1'b0;
        cmd.do_lookup = 1'b0;
        cmd.do_walk   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.do_append = start && (req_type == REQ_APPEND);
                cmd.do_lookup = start && (req_type == REQ_LOOKUP);
            end
            ST_WALK:
            begin
                busy        = 1'b1;
                cmd.do_walk = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/core/rlt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlt_datapath: run storage, counters and the lookup accumulator
// Holds the run RAM, a copy of the last run, the run and item counts, and
// the running length sum of a lookup walk.
// ----------------------------------------------------------------------------
module rlt_datapath
    import rlt_pkg::*;
#(
    parameter int RUN_DEPTH       = 64,
    parameter int RUN_LENGTH_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ctrl_cmd_t               cmd,
    output dp_status_t              stat,
    input  logic signed [VAL_W-1:0] append_value,
    input  logic [IDX_W-1:0]        lookup_index,
    output logic                    done,
    output logic signed [VAL_W-1:0] found_value,
    output logic [1:0]              status
);

    localparam int LW    = RUN_LENGTH_BITS;
    localparam int AW    = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
    localparam int UW    = $clog2(RUN_DEPTH + 1);
    localparam int SUM_W = UW + LW;
    localparam int TW    = (SUM_W > IDX_W) ? SUM_W : IDX_W;
    localparam int EW    = VAL_W + LW;
    localparam logic [LW-1:0] LEN_MAX = {LW{1'b1}};

    logic [UW-1:0]           used_reg,  used_next;
    logic [TW-1:0]           total_reg, total_next;
    logic signed [VAL_W-1:0] last_value_reg, last_value_next;
    logic [LW-1:0]           last_len_reg,   last_len_next;
    logic [TW-1:0]           idx_reg,   idx_next;
    logic [TW-1:0]           sum_reg,   sum_next;
    logic [AW-1:0]           walk_reg,  walk_next;
    logic                    done_reg,  done_next;
    logic signed [VAL_W-1:0] found_reg, found_next;
    status_t                 status_reg, status_next;

    logic           we;
    logic [AW-1:0]  waddr;
    logic [EW-1:0]  wdata;
    logic [AW-1:0]  raddr;
    logic [EW-1:0]  rdata;

    logic [UW-1:0]  last_run;
    logic           extend;
    logic           full;
    logic [TW-1:0]  sum_acc;

    rlt_ram #(
        .WIDTH (EW),
        .DEPTH (RUN_DEPTH)
    ) u_runs (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign last_run = used_reg - 1'b1;
    assign extend   = (used_reg != '0) && (last_value_reg == append_value)
                      && (last_len_reg != LEN_MAX);
    assign full     = (used_reg == UW'(RUN_DEPTH));

    // entry layout is {value, length}
    assign sum_acc       = sum_reg + TW'(rdata[LW-1:0]);
    assign stat.hit      = cmd.do_walk && (sum_acc > idx_reg);
    assign stat.in_range = (TW'(lookup_index) < total_reg);

    // address the first run while idle so a lookup finds it ready
    assign raddr = cmd.do_walk ? (walk_reg + 1'b1) : '0;

    always_comb
    begin
        used_next       = used_reg;
        total_next      = total_reg;
        last_value_next = last_value_reg;
        last_len_next   = last_len_reg;
        idx_next        = idx_reg;
        sum_next        = sum_reg;
        walk_next       = walk_reg;
        done_next       = 1'b0;
        found_next      = found_reg;
        status_next     = status_reg;
        we              = 1'b0;
        waddr           = '0;
        wdata           = '0;

        if (cmd.do_append)
        begin
            done_next  = 1'b1;
            found_next = '0;
            if (extend)
            begin
                we            = 1'b1;
                waddr         = last_run[AW-1:0];
                wdata         = {last_value_reg, last_len_reg + 1'b1};
                last_len_next = last_len_reg + 1'b1;
                total_next    = total_reg + 1'b1;
                status_next   = STATUS_OK;
            end
            else if (full)
            begin
                status_next = STATUS_FULL;
            end
            else
            begin
                we              = 1'b1;
                waddr           = used_reg[AW-1:0];
                wdata           = {append_value, LW'(1)};
                last_value_next = append_value;
                last_len_next   = LW'(1);
                used_next       = used_reg + 1'b1;
                total_next      = total_reg + 1'b1;
                status_next     = STATUS_OK;
            end
        end

        if (cmd.do_lookup)
        begin
            idx_next  = TW'(lookup_index);
            sum_next  = '0;
            walk_next = '0;
            if (!stat.in_range)
            begin
                done_next   = 1'b1;
                found_next  = '0;
                status_next = STATUS_RANGE;
            end
        end

        if (cmd.do_walk)
        begin
            sum_next  = sum_acc;
            walk_next = walk_reg + 1'b1;
            if (stat.hit)
            begin
                done_next   = 1'b1;
                found_next  = rdata[EW-1:LW];
                status_next = STATUS_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg  <= '0;
            total_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            used_reg  <= used_next;
            total_reg <= total_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_value_reg <= last_value_next;
        last_len_reg   <= last_len_next;
        idx_reg        <= idx_next;
        sum_reg        <= sum_next;
        walk_reg       <= walk_next;
        found_reg      <= found_next;
        status_reg     <= status_next;
    end

    assign done        = done_reg;
    assign found_value = found_reg;
    assign status      = status_reg;

endmodule

>>> rtl/core/run_length_table_append_lookup_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_length_table_append_lookup_core: run-length table with append/lookup
// Keeps up to RUN_DEPTH (value, length) runs. An append item grows the last
// run or opens a new one (refused with STATUS_FULL when the table is full);
// a lookup item returns the value at a position of the expanded sequence.
//
// Usage:
//  - Offer an item on req_type/append_value/lookup_index with start high; it
//    is taken at the clock edge where start is high and busy is low.
//  - Each item gives exactly one result on found_value/status, shown for a
//    single cycle while done is high. The receiver cannot stall it.
//  - An append, and a lookup out of range, raise done in the cycle after the
//    item is taken; busy stays low, so a new item may follow at once.
//  - A lookup that lands in run k (counted from 0) holds busy while it walks
//    runs 0 to k and raises done through the result register once run k is
//    read. The walk reads one run per cycle through the single read port of
//    the run RAM and accumulates the run lengths.
//  - Reset empties the table (run count and item count go to zero); the run
//    RAM needs no clearing, as only runs below the run count are ever used.
// ----------------------------------------------------------------------------
module run_length_table_append_lookup_core
    import rlt_pkg::*;
#(
    parameter int RUN_DEPTH       = 64,
    parameter int RUN_LENGTH_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    req_type,
    input  logic signed [VAL_W-1:0] append_value,
    input  logic [IDX_W-1:0]        lookup_index,
    output logic                    done,
    output logic signed [VAL_W-1:0] found_value,
    output logic [1:0]              status
);

    ctrl_cmd_t  cmd;
    dp_status_t stat;

    // controller: accept items and step the lookup walk
    rlt_fsm u_fsm (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .stat     (stat),
        .busy     (busy),
        .cmd      (cmd)
    );

    // datapath: run storage, counters and result register
    rlt_datapath #(
        .RUN_DEPTH       (RUN_DEPTH),
        .RUN_LENGTH_BITS (RUN_LENGTH_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .append_value (append_value),
        .lookup_index (lookup_index),
        .done         (done),
        .found_value  (found_value),
        .status       (status)
    );

    // an append always answers in the next cycle
    a_append_answers: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req_type == REQ_APPEND))
        |=> (done && status != STATUS_RANGE))
        else $error("append item gave no result in the next cycle");

    // a result is only ever shown once the walk has ended
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while a lookup is still walking");

    // the walk only opens on a lookup item
    a_walk_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && (req_type == REQ_LOOKUP)))
        else $error("walk opened without a lookup item");

    // errors carry a zero value
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STATUS_OK) |-> (found_value == '0))
        else $error("error result with a non-zero value");

    // the end of a walk is always reported
    a_walk_reports: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (done && status == STATUS_OK))
        else $error("lookup walk ended without a good result");

endmodule
